// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the task dispatch queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks a property on every rising edge of clk outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: rtl/ttdq_pkg.sv
// Shared types, codes and defaults of the timed task dispatch queue.
package ttdq_pkg;

  localparam int READY_DEPTH_DEF = 16;
  localparam int TIMER_SLOTS_DEF = 16;

  // Operation codes carried in the input word's tuser.
  localparam logic [1:0] OP_POST     = 2'd0;
  localparam logic [1:0] OP_DELAYED  = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_DISPATCH = 2'd3;

  // What the head cell does while the slot ring rotates.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_MATCH = 2'd1;
  localparam logic [1:0] MODE_FILL  = 2'd2;

  typedef struct packed {
    logic [7:0]  tid;
    logic [15:0] dly;
  } slot_word_t;

  typedef struct packed {
    logic        shift;
    logic        proc;
    logic [1:0]  mode;
    logic        found;
    logic [7:0]  tid;
    logic [15:0] dly;
  } slot_ctrl_t;

  typedef struct packed {
    logic       fire;
    logic       hit;
    logic [7:0] tid;
  } slot_stat_t;

endpackage

// File: rtl/ttdq_ready_cell.sv
// One entry of the ready queue shift chain.
module ttdq_ready_cell (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop,
  input  logic       push,
  input  logic [7:0] push_data,
  input  logic [7:0] next_entry,
  output logic [7:0] entry
);

  logic [7:0] entry_r;

  // A pop moves every entry one place towards the head.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= 8'd0;
    end else if (pop) begin
      entry_r <= next_entry;
    end else if (push) begin
      entry_r <= push_data;
    end
  end

  assign entry = entry_r;

endmodule

// File: rtl/ttdq_slot_cell.sv
// One timer slot of the rotating slot ring, with its head processing logic.
module ttdq_slot_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ttdq_pkg::slot_ctrl_t  ctrl,
  input  ttdq_pkg::slot_word_t  word_in,
  output ttdq_pkg::slot_word_t  word_out,
  output ttdq_pkg::slot_stat_t  stat
);
  import ttdq_pkg::*;

  logic [7:0]  tid_r;
  logic [15:0] dly_r;
  slot_word_t  proc_word;
  slot_stat_t  proc_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tid_r <= 8'd0;
    end else if (ctrl.shift) begin
      tid_r <= word_in.tid;
    end
  end

  // The delay of a free slot is never looked at, so it needs no reset.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      dly_r <= word_in.dly;
    end
  end

  always_comb begin
    proc_word.tid = tid_r;
    proc_word.dly = dly_r;
    proc_stat.fire = 1'b0;
    proc_stat.hit = 1'b0;
    proc_stat.tid = tid_r;
    case (ctrl.mode)
      MODE_TICK: begin
        if (tid_r != 8'd0) begin
          if (dly_r != 16'd0) begin
            proc_word.dly = dly_r - 16'd1;
          end else begin
            proc_word.tid = 8'd0;
            proc_stat.fire = 1'b1;
          end
        end
      end
      MODE_MATCH: begin
        if (!ctrl.found && tid_r == ctrl.tid) begin
          proc_word.dly = ctrl.dly;
          proc_stat.hit = 1'b1;
        end
      end
      MODE_FILL: begin
        if (!ctrl.found && tid_r == 8'd0) begin
          proc_word.tid = ctrl.tid;
          proc_word.dly = ctrl.dly;
          proc_stat.hit = 1'b1;
        end
      end
      default: begin
        proc_word.tid = tid_r;
      end
    endcase
  end

  // Only the head cell is enabled to process; the others hand on their word as it is.
  always_comb begin
    if (ctrl.proc) begin
      word_out = proc_word;
      stat = proc_stat;
    end else begin
      word_out.tid = tid_r;
      word_out.dly = dly_r;
      stat = '0;
    end
  end

endmodule

// File: rtl/timed_task_dispatch_queue.sv
// Top level of the timed task dispatch queue: ready queue, timer slot ring and sequencer.
// Usage:
// The input channel (in_*) takes one operation word at a time: in_tuser carries the
// operation (post, delayed post, tick, dispatch), in_tdata the task id and the delay.
// The output channel (out_*) returns exactly one result word per operation: the task
// dispatched, a dropped flag, the ready queue count and the number of timers fired.
// Post and dispatch finish in the cycle they are accepted; their result then goes
// from the done state into the output register and shows on out_tvalid. A tick
// rotates the ring of TIMER_SLOTS cells once, one slot through the head cell per
// cycle. A delayed post first rotates the ring looking for its id, and if it is not
// found rotates it again for the first free slot. A delayed post of the idle id is
// answered like a post. The input is ready again in the cycle after the result is
// loaded. The head cell is the single processing path; one operation is worked on at
// a time, and the next is taken once the current result has gone to the output
// register, even while that register still waits for out_tready.
// Reset (rst_n low, synchronous) empties the ready queue and frees every timer slot.
// A stalled receiver holds the result word; the next operation still runs, then waits.
module timed_task_dispatch_queue #(
  parameter int READY_DEPTH = ttdq_pkg::READY_DEPTH_DEF,
  parameter int TIMER_SLOTS = ttdq_pkg::TIMER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // task_id [7:0], delay [23:8]
  input  logic [1:0]  in_tuser,   // op [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // run_task [7:0], dropped [8], ready_count [13:9],
                                  // fired_count [18:14], zero [23:19]
);
  import ttdq_pkg::*;

  localparam int FW  = $clog2(READY_DEPTH + 1);
  localparam int CW  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int FCW = $clog2(TIMER_SLOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]     state_r, state_nxt;
  logic [1:0]     mode_r, mode_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [7:0]     tid_r, tid_nxt;
  logic [15:0]    dly_r, dly_nxt;
  logic           found_r, found_nxt;
  logic           lost_r, lost_nxt;
  logic [FCW-1:0] fired_r, fired_nxt;
  logic [7:0]     run_r, run_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [23:0]    out_data_r, out_data_nxt;

  logic           accept;
  logic           disp_empty;
  logic           push_en, pop_en, shift_en, out_load;
  logic [7:0]     push_data;
  logic [7:0]     in_task_id;
  logic [15:0]    in_delay;
  logic [4:0]     ready_cnt, fired_cnt;
  logic [31:0]    fill_ext, fired_ext;

  logic [7:0]     entry [READY_DEPTH];
  slot_word_t     ring_word [TIMER_SLOTS];
  slot_stat_t     ring_stat [TIMER_SLOTS];
  slot_ctrl_t     ring_ctrl [TIMER_SLOTS];
  slot_stat_t     head_stat;

  assign in_task_id = in_tdata[7:0];
  assign in_delay   = in_tdata[23:8];
  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign head_stat  = ring_stat[0];
  assign disp_empty = accept && (in_tuser == OP_DISPATCH) && (fill_r == '0);

  // Ready queue: a chain of entries that shifts towards the head on a pop.
  for (genvar i = 0; i < READY_DEPTH; i++) begin : g_ready
    logic [7:0] next_e;
    if (i < READY_DEPTH - 1) begin : g_mid
      assign next_e = entry[i+1];
    end else begin : g_last
      assign next_e = 8'd0;
    end
    ttdq_ready_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .pop        (pop_en),
      .push       (push_en && (fill_r == FW'(i))),
      .push_data  (push_data),
      .next_entry (next_e),
      .entry      (entry[i])
    );
  end

  // Timer slots: a ring, turned one slot a cycle during a walk; cell 0 is the head.
  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_slot
    always_comb begin
      ring_ctrl[i].shift = shift_en;
      ring_ctrl[i].proc  = shift_en && (i == 0);
      ring_ctrl[i].mode  = mode_r;
      ring_ctrl[i].found = found_r;
      ring_ctrl[i].tid   = tid_r;
      ring_ctrl[i].dly   = dly_r;
    end
    ttdq_slot_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ring_ctrl[i]),
      .word_in  (ring_word[(i + 1) % TIMER_SLOTS]),
      .word_out (ring_word[i]),
      .stat     (ring_stat[i])
    );
  end

  always_comb begin
    fill_ext  = 32'(fill_r);
    fired_ext = 32'(fired_r);
    ready_cnt = (fill_ext > 32'd31) ? 5'd31 : fill_ext[4:0];
    fired_cnt = (fired_ext > 32'd31) ? 5'd31 : fired_ext[4:0];
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    tid_nxt       = tid_r;
    dly_nxt       = dly_r;
    found_nxt     = found_r;
    lost_nxt      = lost_r;
    fired_nxt     = fired_r;
    run_nxt       = run_r;
    fill_nxt      = fill_r;
    push_en       = 1'b0;
    push_data     = 8'd0;
    pop_en        = 1'b0;
    shift_en      = 1'b0;
    out_load      = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          tid_nxt   = in_task_id;
          dly_nxt   = in_delay;
          found_nxt = 1'b0;
          lost_nxt  = 1'b0;
          fired_nxt = '0;
          run_nxt   = 8'd0;
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
          unique case (in_tuser)
            OP_POST: begin
              if (in_task_id != 8'd0) begin
                if (fill_r == FW'(READY_DEPTH)) begin
                  lost_nxt = 1'b1;
                end else begin
                  push_en   = 1'b1;
                  push_data = in_task_id;
                  fill_nxt  = fill_r + FW'(1);
                end
              end
            end
            OP_DELAYED: begin
              if (in_task_id != 8'd0) begin
                mode_nxt  = MODE_MATCH;
                state_nxt = ST_WALK;
              end
            end
            OP_TICK: begin
              mode_nxt  = MODE_TICK;
              state_nxt = ST_WALK;
            end
            OP_DISPATCH: begin
              if (fill_r != '0) begin
                run_nxt  = entry[0];
                pop_en   = 1'b1;
                fill_nxt = fill_r - FW'(1);
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_WALK: begin
        shift_en = 1'b1;
        cnt_nxt  = cnt_r + CW'(1);
        if (head_stat.hit) begin
          found_nxt = 1'b1;
        end
        if (head_stat.fire) begin
          fired_nxt = fired_r + FCW'(1);
          if (fill_r == FW'(READY_DEPTH)) begin
            lost_nxt = 1'b1;
          end else begin
            push_en   = 1'b1;
            push_data = head_stat.tid;
            fill_nxt  = fill_r + FW'(1);
          end
        end
        // After a full turn every slot is back in its own cell.
        if (cnt_r == CW'(TIMER_SLOTS - 1)) begin
          cnt_nxt = '0;
          if (mode_r == MODE_MATCH && !(found_r || head_stat.hit)) begin
            mode_nxt = MODE_FILL;
          end else begin
            state_nxt = ST_DONE;
            if (mode_r == MODE_FILL && !(found_r || head_stat.hit)) begin
              lost_nxt = 1'b1;
            end
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load     = 1'b1;
          out_data_nxt = {5'd0, fired_cnt, ready_cnt, lost_r, run_r};
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_TICK;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tid_r      <= tid_nxt;
    dly_r      <= dly_nxt;
    lost_r     <= lost_nxt;
    fired_r    <= fired_nxt;
    run_r      <= run_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`include "assert_macros.svh"

  `ASSERT_NEVER(a_fill_bound, fill_r > FW'(READY_DEPTH), "ready queue fill beyond its depth")
  `ASSERT_NEVER(a_push_pop, push_en && pop_en, "push and pop in the same cycle")
  `ASSERT_PROP(a_fired_bound, 32'(fired_r) <= TIMER_SLOTS, "more timers fired than slots")
  `ASSERT_PROP(a_empty_dispatch, disp_empty |=> (run_r == 8'd0), "empty dispatch gave a task")

endmodule

// File: tb/sv/ttdq_checker.sv
`timescale 1ns / 1ps
// Result checker for the timed task dispatch queue: predicts every result word and compares it.
module ttdq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // task_id [7:0], delay [23:8]
  input  logic [1:0]  in_tuser,   // op [1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // run_task [7:0], dropped [8], ready_count [13:9],
                                  // fired_count [18:14], zero [23:19]
  output int          fail_count,
  output int          pending_words
);
  import ttdq_pkg::*;

  localparam int READY_DEPTH = READY_DEPTH_DEF;
  localparam int TIMER_SLOTS = TIMER_SLOTS_DEF;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [4:0] pad;
    logic [4:0] fired_count;
    logic [4:0] ready_count;
    logic       dropped;
    logic [7:0] run_task;
  } result_word_t;

  typedef struct {
    int           seq;
    result_word_t word;
  } expected_word_t;

  logic [7:0]     ready_ids [READY_DEPTH];
  int             ready_fill;
  logic [7:0]     slot_ids [TIMER_SLOTS];
  logic [15:0]    slot_ticks [TIMER_SLOTS];
  expected_word_t expected_results [$];
  int             ops_seen;

  function automatic logic [4:0] clip5(input int n);
    return (n > 31) ? 5'd31 : 5'(n);
  endfunction

  // Appends a task to the ready queue; returns 0 when the queue is already full.
  function automatic bit push_ready(input logic [7:0] tid);
    if (ready_fill >= READY_DEPTH) return 1'b0;
    ready_ids[ready_fill] = tid;
    ready_fill++;
    return 1'b1;
  endfunction

  // Applies one operation to the scheduler state and gives the word it should produce.
  function automatic result_word_t schedule_op(input logic [1:0] op, input logic [7:0] tid,
                                               input logic [15:0] dly);
    result_word_t res;
    bit           placed;
    int           fired;
    res    = '0;
    placed = 1'b0;
    fired  = 0;
    case (op)
      OP_POST: begin
        if (tid != 8'd0 && !push_ready(tid)) res.dropped = 1'b1;
      end
      OP_DELAYED: begin
        if (tid != 8'd0) begin
          // An existing slot with the same task only has its delay replaced.
          for (int i = 0; i < TIMER_SLOTS && !placed; i++) begin
            if (slot_ids[i] == tid) begin
              slot_ticks[i] = dly;
              placed = 1'b1;
            end
          end
          for (int i = 0; i < TIMER_SLOTS && !placed; i++) begin
            if (slot_ids[i] == 8'd0) begin
              slot_ids[i]   = tid;
              slot_ticks[i] = dly;
              placed = 1'b1;
            end
          end
          if (!placed) res.dropped = 1'b1;
        end
      end
      OP_TICK: begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (slot_ids[i] != 8'd0) begin
            if (slot_ticks[i] != 16'd0) begin
              slot_ticks[i] = slot_ticks[i] - 16'd1;
            end else begin
              // The slot is freed even when its task cannot be queued.
              if (!push_ready(slot_ids[i])) res.dropped = 1'b1;
              slot_ids[i] = 8'd0;
              fired++;
            end
          end
        end
      end
      default: begin
        if (ready_fill > 0) begin
          res.run_task = ready_ids[0];
          for (int i = 0; i < READY_DEPTH - 1; i++) ready_ids[i] = ready_ids[i + 1];
          ready_ids[READY_DEPTH - 1] = 8'd0;
          ready_fill--;
        end
      end
    endcase
    res.ready_count = clip5(ready_fill);
    res.fired_count = clip5(fired);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int seq, input logic [15:0] got,
                                 input logic [15:0] want);
    fail_count++;
    if (fail_count <= PRINT_LIMIT)
      $display("[%0t] operation %0d: %s is 0x%0h, expected 0x%0h", $time, seq, what, got, want);
  endtask

  always @(posedge clk) begin
    expected_word_t head;
    result_word_t   got;
    if (!rst_n) begin
      ready_ids  = '{default: '0};
      slot_ids   = '{default: '0};
      slot_ticks = '{default: '0};
      ready_fill = 0;
      ops_seen   = 0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result word", -1, got[15:0], 16'd0);
        end else begin
          head = expected_results.pop_front();
          if (got.run_task !== head.word.run_task)
            report_mismatch("run_task", head.seq, 16'(got.run_task),
                            16'(head.word.run_task));
          if (got.dropped !== head.word.dropped)
            report_mismatch("dropped", head.seq, 16'(got.dropped),
                            16'(head.word.dropped));
          if (got.ready_count !== head.word.ready_count)
            report_mismatch("ready_count", head.seq, 16'(got.ready_count),
                            16'(head.word.ready_count));
          if (got.fired_count !== head.word.fired_count)
            report_mismatch("fired_count", head.seq, 16'(got.fired_count),
                            16'(head.word.fired_count));
          if (got.pad !== head.word.pad)
            report_mismatch("padding", head.seq, 16'(got.pad), 16'(head.word.pad));
        end
      end
      if (in_tvalid && in_tready) begin
        head.seq  = ops_seen;
        head.word = schedule_op(in_tuser, in_tdata[7:0], in_tdata[23:8]);
        expected_results.push_back(head);
        ops_seen++;
      end
    end
    pending_words = expected_results.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the timed task dispatch queue testbench: clock, reset, operation stimulus and verdict.
module testbench;
  import ttdq_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int TOTAL_OPS   = 440;
  localparam int LONG_HOLD   = 300;

  typedef enum int {EP_MIX, EP_FILL_QUEUE, EP_FILL_SLOTS, EP_DRAIN, EP_NOISE} episode_t;
  typedef enum int {RX_STEADY, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_style_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // task_id [7:0], delay [23:8]
  logic [1:0]  in_tuser   = '0;   // op [1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // run_task [7:0], dropped [8], ready_count [13:9],
                                  // fired_count [18:14], zero [23:19]
  int          fail_count;
  int          pending_words;

  int items_sent;
  int burst_left;
  int cycle_count;
  bit steady_sender;
  bit long_hold_req;
  bit long_hold_done;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  timed_task_dispatch_queue i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ttdq_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  // Offers one operation word, waits for it to be taken, then perhaps leaves a gap.
  task automatic issue_op(input logic [1:0] op, input logic [7:0] tid, input logic [15:0] dly);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {dly, tid};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if (steady_sender) gap = 0;
      else if ($urandom_range(0, 7) == 0) gap = $urandom_range(10, 40);
      else gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        in_tuser  <= 2'($urandom);
        in_tdata  <= 24'($urandom);
      end
      burst_left = $urandom_range(0, 12);
    end
  endtask

  initial begin : stimulus
    logic [1:0]  op;
    logic [7:0]  tid;
    logic [15:0] dly;
    episode_t    kind;
    int          len;
    int          r;
    int          base;
    bit          drained;
    drained = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty queue, idle ids, extreme ids and delays, delay update.
    issue_op(OP_DISPATCH, 8'd0,   16'd0);
    issue_op(OP_TICK,     8'd0,   16'd0);
    issue_op(OP_POST,     8'd0,   16'hFFFF);
    issue_op(OP_DELAYED,  8'd0,   16'hFFFF);
    issue_op(OP_POST,     8'hFF,  16'd0);
    issue_op(OP_POST,     8'h01,  16'hFFFF);
    issue_op(OP_DELAYED,  8'hAA,  16'hFFFF);
    issue_op(OP_DELAYED,  8'h55,  16'd0);
    issue_op(OP_DELAYED,  8'h80,  16'd1);
    issue_op(OP_DELAYED,  8'hAA,  16'd2);
    issue_op(OP_TICK,     8'hFF,  16'hFFFF);
    issue_op(OP_TICK,     8'd0,   16'd0);
    issue_op(OP_TICK,     8'd0,   16'd0);
    issue_op(OP_DISPATCH, 8'hFF,  16'hFFFF);
    issue_op(OP_TICK,     8'd0,   16'd0);
    issue_op(OP_DISPATCH, 8'd0,   16'd0);
    issue_op(OP_DISPATCH, 8'd0,   16'd0);
    issue_op(OP_DISPATCH, 8'd0,   16'd0);
    issue_op(OP_DISPATCH, 8'd0,   16'd0);
    issue_op(OP_DISPATCH, 8'd0,   16'd0);

    while (items_sent < TOTAL_OPS) begin
      r = $urandom_range(0, 99);
      if (r < 35)      kind = EP_MIX;
      else if (r < 50) kind = EP_FILL_QUEUE;
      else if (r < 65) kind = EP_FILL_SLOTS;
      else if (r < 85) kind = EP_DRAIN;
      else             kind = EP_NOISE;
      len  = (kind == EP_FILL_SLOTS) ? $urandom_range(18, 26) : $urandom_range(8, 30);
      base = $urandom_range(0, 254);
      steady_sender = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        case (kind)
          EP_MIX: begin
            op  = 2'($urandom_range(0, 3));
            tid = (r < 6) ? 8'd0 : 8'($urandom_range(1, 24));
            dly = (r > 94) ? 16'($urandom) : 16'($urandom_range(0, 5));
          end
          EP_FILL_QUEUE: begin
            op  = (r < 75) ? OP_POST : ((r < 88) ? OP_TICK : OP_DISPATCH);
            tid = 8'($urandom_range(1, 255));
            dly = 16'($urandom_range(0, 3));
          end
          EP_FILL_SLOTS: begin
            // Distinct ids can overrun the free slots, then ticks push them into the queue.
            op  = (k < len - 5) ? OP_DELAYED : OP_TICK;
            tid = 8'((base + k) % 255 + 1);
            dly = 16'($urandom_range(0, 4));
          end
          EP_DRAIN: begin
            op  = (r < 60) ? OP_DISPATCH : ((r < 90) ? OP_TICK : OP_POST);
            tid = 8'($urandom_range(1, 24));
            dly = 16'($urandom_range(0, 5));
          end
          default: begin
            op  = 2'($urandom_range(0, 3));
            tid = 8'($urandom);
            dly = 16'($urandom);
            // Long delays stay on ids that later words will reschedule.
            if (op == OP_DELAYED) tid = 8'($urandom_range(1, 24));
          end
        endcase
        issue_op(op, tid, dly);
      end
      if (!long_hold_req && items_sent > 150) long_hold_req = 1'b1;
      if (!drained && items_sent > 300) begin
        drained = 1'b1;
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (pending_words != 0) @(negedge clk);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (2 * TIMER_SLOTS_DEF + 8) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // The receiver changes its stall style every so often and holds off once for a long while.
  initial begin : receiver
    int        hold_left;
    int        style_left;
    rx_style_t style;
    hold_left  = 0;
    style_left = 0;
    style      = RX_STEADY;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = rx_style_t'($urandom_range(0, 3));
          style_left = $urandom_range(10, 80);
        end
        style_left--;
        case (style)
          RX_STEADY: out_tready <= 1'b1;
          RX_HALF:   out_tready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:   out_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
